[rtl/reaction_diffusion_stencil_macros.svh]
// Assertion macros shared by the stencil block.
`ifndef REACTION_DIFFUSION_STENCIL_MACROS_SVH
`define REACTION_DIFFUSION_STENCIL_MACROS_SVH
`ifndef SYNTHESIS
`define RDS_ASSERT(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("stencil assertion failed");
`define RDS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("stencil assertion failed");
`else
`define RDS_ASSERT(label, clk, rst_n, expr)
`define RDS_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[rtl/rds_pkg.sv]
`default_nettype none
package rds_pkg;
	localparam int MAX_SIDE_DEF = 32;
	localparam int CNT_W = 6;
	localparam int DATA_W = 32;
	localparam int Q_DEPTH = 4;
	localparam logic [CNT_W-1:0] GRID_RESET = 6'd32;
	localparam logic [CNT_W-1:0] GRID_MIN = 6'd3;
	localparam logic [DATA_W-1:0] GAIN_RESET = 32'h0001_0000;

	localparam logic [1:0] REG_GRID = 2'd0;
	localparam logic [1:0] REG_ALPHA = 2'd1;
	localparam logic [1:0] REG_BETA = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic signed [DATA_W-1:0] prev;
		logic signed [DATA_W-1:0] ew;
		logic signed [DATA_W-1:0] ns;
	} pend_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic signed [DATA_W-1:0] prev;
		logic signed [DATA_W-1:0] ew;
		logic signed [DATA_W-1:0] ns;
		logic [CNT_W-1:0] col;
		logic [CNT_W-1:0] row;
		logic has_res;
		logic flush;
	} item_t;
endpackage
`default_nettype wire

[rtl/reaction_diffusion_stencil.sv]
// Channel   Handshake                Payload
// in        in_valid / in_stall      sample, previous_value, edge_ew, edge_ns
// out       out_valid / out_stall    residual, column, row, last_point
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// An item of row zero is retired when popped and gives no result.
// Other items pass load, multiply, round, beta and emit before the next pop.
// After the last grid item each top-row point is flushed the same way, in turn.
// Reset clears the counters, queue and sequencer; the line stores are not cleared.
// Input is stalled only while the four-entry queue is full.
`default_nettype none
`include "reaction_diffusion_stencil_macros.svh"
module reaction_diffusion_stencil #(
	parameter int MAX_SIDE = rds_pkg::MAX_SIDE_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [rds_pkg::DATA_W-1:0] sample,
	input wire logic signed [rds_pkg::DATA_W-1:0] previous_value,
	input wire logic signed [rds_pkg::DATA_W-1:0] edge_ew,
	input wire logic signed [rds_pkg::DATA_W-1:0] edge_ns,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [rds_pkg::DATA_W-1:0] residual,
	output logic [rds_pkg::CNT_W-1:0] column,
	output logic [rds_pkg::CNT_W-1:0] row,
	output logic last_point,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [rds_pkg::DATA_W-1:0] cfg_data
);
	logic cfg_we;
	logic [rds_pkg::DATA_W-1:0] alpha_q;
	logic [rds_pkg::DATA_W-1:0] beta_q;
	logic [rds_pkg::CNT_W-1:0] grid;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	rds_pkg::item_t q_din;
	rds_pkg::item_t q_dout;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= rds_pkg::GAIN_RESET;
			beta_q <= rds_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			if (cfg_index == rds_pkg::REG_ALPHA) begin
				alpha_q <= cfg_data;
			end
			if (cfg_index == rds_pkg::REG_BETA) begin
				beta_q <= cfg_data;
			end
		end
	end

	rds_front #(.MAX_SIDE(MAX_SIDE)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.grid_we(cfg_we && cfg_index == rds_pkg::REG_GRID),
		.grid_data(cfg_data[rds_pkg::CNT_W-1:0]),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.previous_value(previous_value),
		.edge_ew(edge_ew),
		.edge_ns(edge_ns),
		.q_full(q_full),
		.q_push(q_push),
		.q_din(q_din),
		.grid(grid)
	);

	rds_fifo #(.DEPTH(rds_pkg::Q_DEPTH)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.din(q_din),
		.pop(q_pop),
		.dout(q_dout),
		.full(q_full),
		.empty(q_empty)
	);

	rds_back #(.MAX_SIDE(MAX_SIDE)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.grid(grid),
		.alpha(alpha_q),
		.beta(beta_q),
		.head(q_dout),
		.empty(q_empty),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.residual(residual),
		.column(column),
		.row(row),
		.last_point(last_point)
	);

	`RDS_ASSERT(a_last_on_diag, clk, arst_n, !(out_valid && last_point) || (row == column))
	`RDS_ASSERT(a_pop_has_item, clk, arst_n, !q_pop || !q_empty)
	`RDS_ASSERT_NEXT(a_full_stalls, clk, arst_n, q_full && !q_pop, in_stall)
endmodule
`default_nettype wire

[rtl/rds_fifo.sv]
`default_nettype none
module rds_fifo #(
	parameter int DEPTH = rds_pkg::Q_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire rds_pkg::item_t din,
	input wire logic pop,
	output rds_pkg::item_t dout,
	output logic full,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rds_pkg::item_t mem [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

[rtl/rds_front.sv]
`default_nettype none
module rds_front #(
	parameter int MAX_SIDE = rds_pkg::MAX_SIDE_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic grid_we,
	input wire logic [rds_pkg::CNT_W-1:0] grid_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [rds_pkg::DATA_W-1:0] sample,
	input wire logic signed [rds_pkg::DATA_W-1:0] previous_value,
	input wire logic signed [rds_pkg::DATA_W-1:0] edge_ew,
	input wire logic signed [rds_pkg::DATA_W-1:0] edge_ns,
	input wire logic q_full,
	output logic q_push,
	output rds_pkg::item_t q_din,
	output logic [rds_pkg::CNT_W-1:0] grid
);
	localparam int W = rds_pkg::CNT_W;
	localparam logic [W-1:0] SIDE_MAX = W'(MAX_SIDE);
	localparam logic [W-1:0] GRID_INIT =
		(rds_pkg::GRID_RESET > SIDE_MAX) ? SIDE_MAX : rds_pkg::GRID_RESET;

	logic [W-1:0] col_q;
	logic [W-1:0] row_q;
	logic [W-1:0] grid_q;
	logic [W-1:0] grid_new;
	logic col_end;
	logic row_end;

	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;
	assign grid = grid_q;
	assign col_end = ((W + 1)'(col_q) + 1'b1) == (W + 1)'(grid_q);
	assign row_end = ((W + 1)'(row_q) + 1'b1) == (W + 1)'(grid_q);

	always_comb begin
		grid_new = grid_data;
		if (grid_new < rds_pkg::GRID_MIN) begin
			grid_new = rds_pkg::GRID_MIN;
		end else if (grid_new > SIDE_MAX) begin
			grid_new = SIDE_MAX;
		end
	end

	always_comb begin
		q_din.sample = sample;
		q_din.prev = previous_value;
		q_din.ew = edge_ew;
		q_din.ns = edge_ns;
		q_din.col = col_q;
		q_din.row = row_q;
		q_din.has_res = (row_q != '0);
		q_din.flush = col_end && row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			grid_q <= GRID_INIT;
		end else if (grid_we) begin
			grid_q <= grid_new;
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

[rtl/rds_back.sv]
`default_nettype none
module rds_back #(
	parameter int MAX_SIDE = rds_pkg::MAX_SIDE_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [rds_pkg::CNT_W-1:0] grid,
	input wire logic [rds_pkg::DATA_W-1:0] alpha,
	input wire logic [rds_pkg::DATA_W-1:0] beta,
	input wire rds_pkg::item_t head,
	input wire logic empty,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [rds_pkg::DATA_W-1:0] residual,
	output logic [rds_pkg::CNT_W-1:0] column,
	output logic [rds_pkg::CNT_W-1:0] row,
	output logic last_point
);
	localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int W = rds_pkg::CNT_W;
	localparam int DW = rds_pkg::DATA_W;
	localparam int PW = 2 * DW + 1;
	localparam int RW = PW - 16;
	localparam int SUM_W = RW + 3;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_LOAD = 3'd1;
	localparam logic [2:0] B_MUL = 3'd2;
	localparam logic [2:0] B_RND = 3'd3;
	localparam logic [2:0] B_BETA = 3'd4;
	localparam logic [2:0] B_EMIT = 3'd5;
	localparam logic [2:0] B_FRD = 3'd6;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

	rds_pkg::pend_t pend_mem [MAX_SIDE];
	logic signed [DW-1:0] old_mem [MAX_SIDE];

	logic [2:0] state_q;
	rds_pkg::item_t cur_q;
	logic fl_q;
	logic [W-1:0] k_q;
	rds_pkg::pend_t pa_q;
	rds_pkg::pend_t pb_q;
	logic signed [DW-1:0] ob_q;
	logic signed [DW-1:0] center_q;
	logic signed [DW-1:0] prev_q;
	logic signed [DW-1:0] last_center_q;
	logic signed [SUM_W-1:0] lin_q;
	logic signed [PW-1:0] as_prod_q;
	logic signed [PW-1:0] ay_prod_q;
	logic signed [2*DW-1:0] ss_q;
	logic signed [SUM_W-1:0] part_q;
	logic signed [DW-1:0] p_q;
	logic signed [PW-1:0] bp_prod_q;
	logic out_valid_q;
	logic signed [DW-1:0] res_q;
	logic [W-1:0] col_out_q;
	logic [W-1:0] row_out_q;
	logic last_q;

	logic [AW-1:0] addr0;
	logic [AW-1:0] addr1;
	logic [W-1:0] pos;
	logic at_east;
	logic signed [DW-1:0] west;
	logic signed [DW-1:0] east;
	logic signed [DW-1:0] south;
	logic signed [DW-1:0] north;
	logic signed [RW-1:0] as_r;
	logic signed [RW-1:0] ay_r;
	logic signed [RW-1:0] bp_r;
	logic signed [2*DW+1:0] p_full;
	logic signed [2*DW+1:0] p_sh;
	logic signed [DW-1:0] p_sat;
	logic signed [SUM_W-1:0] total;
	logic signed [DW-1:0] total_sat;
	logic out_free;
	logic k_last;

	assign pop = (state_q == B_IDLE) && !empty;
	assign addr0 = (state_q == B_FRD) ? k_q[AW-1:0] : head.col[AW-1:0];
	assign addr1 = addr0 + 1'b1;
	assign pos = fl_q ? k_q : cur_q.col;
	assign at_east = ((W + 1)'(pos) + 1'b1) == (W + 1)'(grid);
	assign k_last = ((W + 1)'(k_q) + 1'b1) == (W + 1)'(grid);
	assign west = (pos == '0) ? pa_q.ew : last_center_q;
	assign east = at_east ? pa_q.ew : pb_q.sample;
	assign south = (!fl_q && cur_q.row == W'(1)) ? pa_q.ns : ob_q;
	assign north = fl_q ? pa_q.ns : cur_q.sample;
	assign out_free = !out_valid_q || !out_stall;

	assign as_r = RW'((as_prod_q + PW'(32768)) >>> 16);
	assign ay_r = RW'((ay_prod_q + PW'(32768)) >>> 16);
	assign bp_r = RW'((bp_prod_q + PW'(32768)) >>> 16);
	assign p_full = ((2 * DW + 2)'(center_q) <<< 24) - (2 * DW + 2)'(ss_q)
		+ (2 * DW + 2)'(8388608);
	assign p_sh = p_full >>> 24;

	always_comb begin
		if (p_sh > (2 * DW + 2)'(SAT_HI)) begin
			p_sat = DW'(SAT_HI);
		end else if (p_sh < (2 * DW + 2)'(SAT_LO)) begin
			p_sat = DW'(SAT_LO);
		end else begin
			p_sat = DW'(p_sh);
		end
	end

	assign total = part_q + SUM_W'(bp_r);

	always_comb begin
		if (total > SAT_HI) begin
			total_sat = DW'(SAT_HI);
		end else if (total < SAT_LO) begin
			total_sat = DW'(SAT_LO);
		end else begin
			total_sat = DW'(total);
		end
	end

	always_ff @(posedge clk) begin
		pa_q <= pend_mem[addr0];
		pb_q <= pend_mem[addr1];
		ob_q <= old_mem[addr0];
		if (pop) begin
			pend_mem[addr0] <= '{sample: head.sample, prev: head.prev,
				ew: head.ew, ns: head.ns};
		end
		if (state_q == B_LOAD && !fl_q) begin
			old_mem[cur_q.col[AW-1:0]] <= pa_q.sample;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		unique case (state_q)
			B_LOAD: begin
				center_q <= pa_q.sample;
				prev_q <= pa_q.prev;
				last_center_q <= pa_q.sample;
				lin_q <= SUM_W'(west) + SUM_W'(east) + SUM_W'(south) + SUM_W'(north)
					- (SUM_W'(pa_q.sample) <<< 2);
			end
			B_MUL: begin
				as_prod_q <= $signed({1'b0, alpha}) * PW'(center_q);
				ay_prod_q <= $signed({1'b0, alpha}) * PW'(prev_q);
				ss_q <= center_q * center_q;
			end
			B_RND: begin
				part_q <= lin_q - SUM_W'(as_r) + SUM_W'(ay_r);
				p_q <= p_sat;
			end
			B_BETA: begin
				bp_prod_q <= $signed({1'b0, beta}) * PW'(p_q);
			end
			default: begin
			end
		endcase
		if (state_q == B_EMIT && out_free) begin
			res_q <= total_sat;
			col_out_q <= pos;
			row_out_q <= fl_q ? grid - 1'b1 : cur_q.row - 1'b1;
			last_q <= fl_q && k_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			fl_q <= 1'b0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop && head.has_res) begin
						state_q <= B_LOAD;
					end
				end
				B_LOAD: state_q <= B_MUL;
				B_MUL: state_q <= B_RND;
				B_RND: state_q <= B_BETA;
				B_BETA: state_q <= B_EMIT;
				B_EMIT: begin
					if (out_free) begin
						priority if (!fl_q && cur_q.flush) begin
							fl_q <= 1'b1;
							k_q <= '0;
							state_q <= B_FRD;
						end else if (fl_q && !k_last) begin
							k_q <= k_q + 1'b1;
							state_q <= B_FRD;
						end else begin
							fl_q <= 1'b0;
							state_q <= B_IDLE;
						end
					end
				end
				B_FRD: state_q <= B_LOAD;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign residual = res_q;
	assign column = col_out_q;
	assign row = row_out_q;
	assign last_point = last_q;
endmodule
`default_nettype wire

[test/tb_top.sv]
`default_nettype none
module tb_top;
	typedef struct {
		logic signed [31:0] residual;
		logic [5:0] column;
		logic [5:0] row;
		logic last_point;
	} point_t;

	typedef struct {
		bit is_cfg;
		logic [1:0] index;
		logic [31:0] data;
		logic signed [31:0] sample;
		logic signed [31:0] previous_value;
		logic signed [31:0] edge_ew;
		logic signed [31:0] edge_ns;
		bit typed;
		logic signed [31:0] typed_residual;
	} step_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] sample = 0;
	logic signed [31:0] previous_value = 0;
	logic signed [31:0] edge_ew = 0;
	logic signed [31:0] edge_ns = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] residual;
	logic [5:0] column;
	logic [5:0] row;
	logic last_point;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	reaction_diffusion_stencil uut (.*);

	always #5 clk = ~clk;

	// Shadow of the block's line stores, counters and registers.
	logic signed [31:0] older_line [32];
	logic signed [31:0] pend_line [32];
	logic signed [31:0] pend_prev [32];
	logic signed [31:0] pend_ew [32];
	logic signed [31:0] pend_ns [32];
	int col_cnt, row_cnt, side;
	logic [31:0] alpha_q, beta_q;

	point_t expected_points [$];
	step_t directed [$];
	int errors = 0;
	bit calm = 0;
	int out_wait = 0;
	int accepted = 0;
	int popped = 0;

	function automatic longint round_q(longint v, int k);
		return (v + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic signed [31:0] laplace_point(longint c, longint w, longint e,
			longint s, longint n, longint y);
		longint a, b, p, total;
		a = longint'({32'b0, alpha_q});
		b = longint'({32'b0, beta_q});
		p = clip32(round_q(c * (longint'(1) <<< 24) - c * c, 24));
		total = -4 * c - round_q(a * c, 16) + w + e + s + n + round_q(a * y, 16)
			+ round_q(b * p, 16);
		return 32'(clip32(total));
	endfunction

	function automatic void add_point(logic signed [31:0] r, int c, int rw, bit last);
		point_t pt;
		pt.residual = r;
		pt.column = 6'(c);
		pt.row = 6'(rw);
		pt.last_point = last;
		expected_points.push_back(pt);
	endfunction

	function automatic void predict_item(logic signed [31:0] s, logic signed [31:0] y,
			logic signed [31:0] ew, logic signed [31:0] ns);
		int c, r;
		longint south, west, east;
		c = col_cnt;
		r = row_cnt;
		if (r >= 1) begin
			south = (r == 1) ? pend_ns[c] : older_line[c];
			west = (c > 0) ? older_line[c-1] : pend_ew[c];
			east = (c + 1 < side) ? pend_line[c+1] : pend_ew[c];
			add_point(laplace_point(pend_line[c], west, east, south, s, pend_prev[c]),
				c, r - 1, 0);
			older_line[c] = pend_line[c];
		end
		pend_line[c] = s;
		pend_prev[c] = y;
		pend_ew[c] = ew;
		pend_ns[c] = ns;
		if (c + 1 == side && r + 1 == side) begin
			for (int k = 0; k < side; k++) begin
				west = (k > 0) ? pend_line[k-1] : pend_ew[k];
				east = (k + 1 < side) ? pend_line[k+1] : pend_ew[k];
				add_point(laplace_point(pend_line[k], west, east, older_line[k], pend_ns[k],
					pend_prev[k]), k, side - 1, k + 1 == side);
			end
			col_cnt = 0;
			row_cnt = 0;
		end else begin
			c++;
			if (c == side) begin
				c = 0;
				r++;
			end
			col_cnt = c;
			row_cnt = r;
		end
	endfunction

	function automatic void apply_register(logic [1:0] idx, logic [31:0] d);
		int v;
		if (idx == rds_pkg::REG_GRID) begin
			v = d[5:0];
			if (v < 3)
				v = 3;
			if (v > 32)
				v = 32;
			side = v;
			col_cnt = 0;
			row_cnt = 0;
		end else if (idx == rds_pkg::REG_ALPHA) begin
			alpha_q = d;
		end else if (idx == rds_pkg::REG_BETA) begin
			beta_q = d;
		end
	endfunction

	function automatic int draw_wait();
		if (calm)
			return 0;
		return (($urandom % 3) == 0) ? $urandom_range(0, 19) : 0;
	endfunction

	always @(posedge clk) begin
		point_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected item residual=%h col=%0d row=%0d", $time,
					residual, column, row);
				errors++;
			end else begin
				e = expected_points.pop_front();
				popped++;
				if (residual !== e.residual) begin
					$display("%0t: residual expected %h actual %h", $time, e.residual,
						residual);
					errors++;
				end
				if (column !== e.column) begin
					$display("%0t: column expected %0d actual %0d", $time, e.column, column);
					errors++;
				end
				if (row !== e.row) begin
					$display("%0t: row expected %0d actual %0d", $time, e.row, row);
					errors++;
				end
				if (last_point !== e.last_point) begin
					$display("%0t: last_point expected %b actual %b", $time, e.last_point,
						last_point);
					errors++;
				end
			end
			out_wait = draw_wait();
		end else if (out_wait > 0) begin
			out_wait--;
		end
		out_stall <= (out_wait != 0);
	end

	task automatic send_item(logic signed [31:0] s, logic signed [31:0] y,
			logic signed [31:0] ew, logic signed [31:0] ns);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		sample <= s;
		previous_value <= y;
		edge_ew <= ew;
		edge_ns <= ns;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_item(s, y, ew, ns);
		accepted++;
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [31:0] d);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		apply_register(idx, d);
		@(posedge clk);
	endtask

	task automatic dir_cfg(logic [1:0] idx, logic [31:0] d);
		step_t t;
		t = '{default: 0};
		t.is_cfg = 1;
		t.index = idx;
		t.data = d;
		directed.push_back(t);
	endtask

	task automatic dir_item(logic [31:0] s, logic [31:0] y, logic [31:0] ew, logic [31:0] ns,
			bit typed, logic [31:0] r);
		step_t t;
		t = '{default: 0};
		t.sample = s;
		t.previous_value = y;
		t.edge_ew = ew;
		t.edge_ns = ns;
		t.typed = typed;
		t.typed_residual = r;
		directed.push_back(t);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom % 5)
			0: return $urandom;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom % 5)
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 32'h0004_0000);
		endcase
	endfunction

	initial begin
		int n, count, base;
		logic [31:0] g;
		apply_register(rds_pkg::REG_GRID, 32);
		alpha_q = rds_pkg::GAIN_RESET;
		beta_q = rds_pkg::GAIN_RESET;
		col_cnt = 0;
		row_cnt = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Zero samples with zero gains and zero boundaries give zero everywhere.
		dir_cfg(rds_pkg::REG_GRID, 3);
		dir_cfg(rds_pkg::REG_ALPHA, 0);
		dir_cfg(rds_pkg::REG_BETA, 0);
		for (int i = 0; i < 9; i++)
			dir_item(0, 0, 0, 0, i >= 3, 0);
		// Undersized grid, full gains and extreme values to drive saturation.
		dir_cfg(rds_pkg::REG_GRID, 0);
		dir_cfg(rds_pkg::REG_ALPHA, 32'hFFFF_FFFF);
		dir_cfg(rds_pkg::REG_BETA, 32'hFFFF_FFFF);
		for (int i = 0; i < 9; i++)
			dir_item(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
				i[1] ? 32'h8000_0000 : 32'h7FFF_FFFF, i[2] ? 32'h7FFF_FFFF : 32'h8000_0000, 0, 0);
		dir_cfg(rds_pkg::REG_GRID, 63);
		dir_cfg(rds_pkg::REG_ALPHA, rds_pkg::GAIN_RESET);
		dir_cfg(rds_pkg::REG_BETA, rds_pkg::GAIN_RESET);

		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				drain();
				write_register(directed[i].index, directed[i].data);
			end else begin
				base = popped + expected_points.size();
				send_item(directed[i].sample, directed[i].previous_value,
					directed[i].edge_ew, directed[i].edge_ns);
				if (directed[i].typed && expected_points[base - popped].residual !==
						directed[i].typed_residual) begin
					$display("%0t: residual expected %h actual %h", $time,
						directed[i].typed_residual, expected_points[base - popped].residual);
					errors++;
				end
			end
		end

		while (accepted < 410) begin
			drain();
			calm = ($urandom % 4) == 0;
			case ($urandom % 10)
				0: g = $urandom_range(0, 2);
				1: g = $urandom_range(32, 63);
				default: g = $urandom_range(3, 8);
			endcase
			write_register(rds_pkg::REG_GRID, g);
			if ($urandom % 2)
				write_register(rds_pkg::REG_ALPHA, pick_gain());
			if ($urandom % 2)
				write_register(rds_pkg::REG_BETA, pick_gain());
			n = side;
			if (n == 32)
				count = $urandom_range(40, 100);
			else
				count = n * n * $urandom_range(1, 3) + $urandom_range(0, 2 * n);
			if (count > 410 - accepted)
				count = 410 - accepted;
			for (int i = 0; i < count; i++) begin
				if (($urandom % 60) == 0) begin
					in_valid <= 0;
					@(posedge clk);
					while (expected_points.size() != 0)
						@(posedge clk);
				end
				send_item(pick_value(), pick_value(), pick_value(), pick_value());
			end
		end
		drain();
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb_top: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/rds_pkg.sv
rtl/rds_fifo.sv
rtl/rds_front.sv
rtl/rds_back.sv
rtl/reaction_diffusion_stencil.sv
test/tb_top.sv
